>>> rtl/jdi_pkg.sv
// Shared types and constants for the Jacobian determinant and inverse block.
// No dependencies.
package jdi_pkg;

  localparam int INV_W    = 32;  // Q16.16 inverse entry
  localparam int INV_FRAC = 16;
  localparam int DETM_W   = 48;  // Q12.36 determinant magnitude
  localparam int DET_FRAC = 36;
  localparam int QUOT_BITS = 32; // quotient bits developed by the divider

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NEG_DET  = 2'd1,
    STATUS_SINGULAR = 2'd2
  } status_e;

endpackage

>>> rtl/jdi_if.sv
// Valid/ready channel interfaces: Jacobian beat in, inverse/determinant beat out.
// Depends on jdi_pkg.
interface jdi_in_if #(
  parameter int EntryBits = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [EntryBits-1:0] row0_col0;
  logic signed [EntryBits-1:0] row1_col0;
  logic signed [EntryBits-1:0] row2_col0;
  logic signed [EntryBits-1:0] row0_col1;
  logic signed [EntryBits-1:0] row1_col1;
  logic signed [EntryBits-1:0] row2_col1;
  logic signed [EntryBits-1:0] row0_col2;
  logic signed [EntryBits-1:0] row1_col2;
  logic signed [EntryBits-1:0] row2_col2;

  modport source (
    output valid, row0_col0, row1_col0, row2_col0, row0_col1, row1_col1, row2_col1,
           row0_col2, row1_col2, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row1_col0, row2_col0, row0_col1, row1_col1, row2_col1,
           row0_col2, row1_col2, row2_col2,
    output ready
  );
endinterface

interface jdi_out_if ();
  logic                             valid;
  logic                             ready;
  logic signed [jdi_pkg::INV_W-1:0] inv_row0_col0;
  logic signed [jdi_pkg::INV_W-1:0] inv_row1_col0;
  logic signed [jdi_pkg::INV_W-1:0] inv_row2_col0;
  logic signed [jdi_pkg::INV_W-1:0] inv_row0_col1;
  logic signed [jdi_pkg::INV_W-1:0] inv_row1_col1;
  logic signed [jdi_pkg::INV_W-1:0] inv_row2_col1;
  logic signed [jdi_pkg::INV_W-1:0] inv_row0_col2;
  logic signed [jdi_pkg::INV_W-1:0] inv_row1_col2;
  logic signed [jdi_pkg::INV_W-1:0] inv_row2_col2;
  logic        [jdi_pkg::DETM_W-1:0] det_magnitude;
  logic        [1:0]                 status;
  logic                              saturated;

  modport source (
    output valid, inv_row0_col0, inv_row1_col0, inv_row2_col0, inv_row0_col1,
           inv_row1_col1, inv_row2_col1, inv_row0_col2, inv_row1_col2, inv_row2_col2,
           det_magnitude, status, saturated,
    input  ready
  );
  modport sink (
    input  valid, inv_row0_col0, inv_row1_col0, inv_row2_col0, inv_row0_col1,
           inv_row1_col1, inv_row2_col1, inv_row0_col2, inv_row1_col2, inv_row2_col2,
           det_magnitude, status, saturated,
    output ready
  );
endinterface

>>> rtl/jacobian_det_and_inverse.sv
// Top level: pipelined 3x3 (or 2x2, 1x1) Jacobian determinant and inverse.
// Depends on jdi_pkg and the channel interfaces in jdi_if.sv.
//
// Usage:
// - in_i carries one Jacobian per beat, nine signed Q4.(ENTRY_BITS-4) entries;
//   out_o carries the Q16.16 inverse, |det| in Q12.36, status and a saturation flag.
// - The in_i interface instance must be built with EntryBits = ENTRY_BITS.
// - cfg_we_i/cfg_wdata_i write the matrix order (1..3, 0 acts as 1); write it only
//   while the pipeline is empty.
// - Throughput: one beat per cycle while out_o is not stalled. Pipeline: five
//   arithmetic stages (entries, minor products, adjugate, det products, det sum), one
//   setup stage, 32 restoring-division stages (one quotient bit each, nine lanes) and
//   the output register.
// - Stall: the whole pipeline freezes while out_o holds an untaken beat, so
//   in_i.ready follows out_o.ready combinationally; nothing is dropped or repeated.
// - Reset clears every stage valid bit and sets the order to 3.
module jacobian_det_and_inverse #(
  parameter int ENTRY_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  jdi_in_if.sink     in_i,
  jdi_out_if.source  out_o
);

  localparam int E    = ENTRY_BITS;
  localparam int FRAC = E - 4;
  localparam int PW   = 2 * E;          // minor product
  localparam int AW   = 2 * E + 1;      // adjugate entry
  localparam int DPW  = E + AW;         // det partial product
  localparam int DW   = 3 * E + 3;      // signed determinant
  localparam int MW   = DW;             // unsigned magnitude
  localparam int NSH  = jdi_pkg::INV_FRAC + FRAC;
  localparam int NW   = AW + NSH;       // dividend width
  localparam int QB   = jdi_pkg::QUOT_BITS;
  localparam int S1   = jdi_pkg::DET_FRAC - FRAC;
  localparam int S2   = jdi_pkg::DET_FRAC - 2 * FRAC;
  localparam int S3   = jdi_pkg::DET_FRAC - 3 * FRAC;
  localparam int L1   = (S1 >= 0) ? S1 : 0;
  localparam int R1   = (S1 < 0) ? -S1 : 0;
  localparam int L2   = (S2 >= 0) ? S2 : 0;
  localparam int R2   = (S2 < 0) ? -S2 : 0;
  localparam int L3   = (S3 >= 0) ? S3 : 0;
  localparam int R3   = (S3 < 0) ? -S3 : 0;

  typedef struct packed {
    logic [MW-1:0]                 mag;
    logic [jdi_pkg::DETM_W-1:0]    detm;
    logic                          singular;
    logic                          detneg;
    logic [8:0]                    neg;   // per lane, index r*3+c
    logic [8:0]                    ovf;   // quotient needs more than QB bits
  } side_t;

  logic adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // order register
  logic [1:0] order_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 2'd3;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // stage valid bits: 1..5 arithmetic, 6 setup, then division stages
  logic [6:1] v_q;
  logic [QB:1] dv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      dv_q  <= '0;
      out_o.valid <= 1'b0;
    end else if (adv) begin
      v_q   <= {v_q[5:1], in_i.valid};
      dv_q  <= {dv_q[QB-1:1], v_q[6]};
      out_o.valid <= dv_q[QB];
    end
  end

  // ---------------- stage 1: capture entries ----------------
  logic signed [E-1:0] a1_q [3][3];
  logic [1:0]          n1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q[0][0] <= in_i.row0_col0;
      a1_q[1][0] <= in_i.row1_col0;
      a1_q[2][0] <= in_i.row2_col0;
      a1_q[0][1] <= in_i.row0_col1;
      a1_q[1][1] <= in_i.row1_col1;
      a1_q[2][1] <= in_i.row2_col1;
      a1_q[0][2] <= in_i.row0_col2;
      a1_q[1][2] <= in_i.row1_col2;
      a1_q[2][2] <= in_i.row2_col2;
      n1_q       <= (order_q == 2'd0) ? 2'd1 : order_q;
    end
  end

  // ---------------- stage 2: cofactor products ----------------
  logic signed [PW-1:0] pa_d [3][3];
  logic signed [PW-1:0] pb_d [3][3];
  logic signed [PW-1:0] pa2_q [3][3];
  logic signed [PW-1:0] pb2_q [3][3];
  logic signed [E-1:0]  a2_q [3][3];
  logic [1:0]           n2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_d[i][j] = a1_q[(j+1)%3][(i+1)%3] * a1_q[(j+2)%3][(i+2)%3];
        pb_d[i][j] = a1_q[(j+1)%3][(i+2)%3] * a1_q[(j+2)%3][(i+1)%3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa2_q <= pa_d;
      pb2_q <= pb_d;
      a2_q  <= a1_q;
      n2_q  <= n1_q;
    end
  end

  // ---------------- stage 3: adjugate per order ----------------
  logic signed [AW-1:0] adj_d [3][3];
  logic signed [AW-1:0] adj3_q [3][3];
  logic signed [DW-1:0] dalt_d;
  logic signed [DW-1:0] dalt3_q;
  logic signed [E-1:0]  ac3_q [3];
  logic [1:0]           n3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        adj_d[i][j] = '0;
      end
    end
    dalt_d = DW'(a2_q[0][0]);
    case (n2_q)
      2'd3: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            adj_d[i][j] = AW'(pa2_q[i][j]) - AW'(pb2_q[i][j]);
          end
        end
      end
      2'd2: begin
        adj_d[0][0] = AW'(a2_q[1][1]);
        adj_d[0][1] = -AW'(a2_q[0][1]);
        adj_d[1][0] = -AW'(a2_q[1][0]);
        adj_d[1][1] = AW'(a2_q[0][0]);
        dalt_d = DW'(AW'(pa2_q[2][2]) - AW'(pb2_q[2][2]));
      end
      default: begin
        adj_d[0][0] = AW'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      adj3_q  <= adj_d;
      dalt3_q <= dalt_d;
      ac3_q[0] <= a2_q[0][0];
      ac3_q[1] <= a2_q[1][0];
      ac3_q[2] <= a2_q[2][0];
      n3_q    <= n2_q;
    end
  end

  // ---------------- stage 4: first-column expansion products ----------------
  logic signed [DPW-1:0] dp4_q [3];
  logic signed [AW-1:0]  adj4_q [3][3];
  logic signed [DW-1:0]  dalt4_q;
  logic [1:0]            n4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        dp4_q[r] <= ac3_q[r] * adj3_q[0][r];
      end
      adj4_q  <= adj3_q;
      dalt4_q <= dalt3_q;
      n4_q    <= n3_q;
    end
  end

  // ---------------- stage 5: determinant sum ----------------
  logic signed [DW-1:0] det5_q;
  logic signed [AW-1:0] adj5_q [3][3];
  logic [1:0]           n5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det5_q <= (n4_q == 2'd3) ? (DW'(dp4_q[0]) + DW'(dp4_q[1]) + DW'(dp4_q[2]))
                               : dalt4_q;
      adj5_q <= adj4_q;
      n5_q   <= n4_q;
    end
  end

  // ---------------- stage 6: magnitudes, det output, overflow check ----------------
  logic [MW-1:0]  mag6;
  logic [127:0]   magw;
  logic [127:0]   dmw;
  side_t          side6;
  logic [MW-1:0]  rem6 [3][3];
  logic [QB-1:0]  low6 [3][3];
  logic [AW-1:0]  vmag;
  logic [NW-1:0]  numer;

  always_comb begin
    mag6 = det5_q[DW-1] ? MW'(unsigned'(-det5_q)) : MW'(unsigned'(det5_q));
    magw = 128'(mag6);
    case (n5_q)
      2'd3:    dmw = (magw << L3) >> R3;
      2'd2:    dmw = (magw << L2) >> R2;
      default: dmw = (magw << L1) >> R1;
    endcase
    side6.mag      = mag6;
    side6.detm     = dmw[jdi_pkg::DETM_W-1:0];
    side6.singular = (det5_q == '0);
    side6.detneg   = det5_q[DW-1];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        vmag  = adj5_q[r][c][AW-1] ? unsigned'(-adj5_q[r][c]) : unsigned'(adj5_q[r][c]);
        numer = {vmag, {NSH{1'b0}}};
        side6.neg[r*3+c] = adj5_q[r][c][AW-1] ^ det5_q[DW-1];
        side6.ovf[r*3+c] = MW'(numer[NW-1:QB]) >= mag6;
        rem6[r][c] = MW'(numer[NW-1:QB]);
        low6[r][c] = numer[QB-1:0];
      end
    end
  end

  // division pipeline: index 0 is the setup register
  side_t         side_q [QB+1];
  logic [MW-1:0] rem_q  [QB+1][3][3];
  logic [QB-1:0] low_q  [QB+1][3][3];
  logic [QB-1:0] quo_q  [QB+1][3][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side6;
      rem_q[0]  <= rem6;
      low_q[0]  <= low6;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          quo_q[0][r][c] <= '0;
        end
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [MW:0] t_d [3][3];
    logic        ge_d [3][3];

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          t_d[r][c]  = {rem_q[k-1][r][c], low_q[k-1][r][c][QB-1]};
          ge_d[r][c] = t_d[r][c] >= {1'b0, side_q[k-1].mag};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= side_q[k-1];
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            rem_q[k][r][c] <= ge_d[r][c] ? MW'(t_d[r][c] - {1'b0, side_q[k-1].mag})
                                         : t_d[r][c][MW-1:0];
            low_q[k][r][c] <= {low_q[k-1][r][c][QB-2:0], 1'b0};
            quo_q[k][r][c] <= {quo_q[k-1][r][c][QB-2:0], ge_d[r][c]};
          end
        end
      end
    end
  end

  // ---------------- output stage: saturate, sign, status ----------------
  side_t                            sf;
  logic signed [jdi_pkg::INV_W-1:0] inv_d [3][3];
  logic [QB:0]                      lim;
  logic [QB-1:0]                    qs;
  logic                             sat_lane;
  logic                             sat_d;
  logic [1:0]                       status_d;

  always_comb begin
    sf    = side_q[QB];
    sat_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lim      = sf.neg[r*3+c] ? (QB+1)'(1) << (QB-1) : ((QB+1)'(1) << (QB-1)) - 1'b1;
        sat_lane = sf.ovf[r*3+c] || ({1'b0, quo_q[QB][r][c]} > lim);
        qs       = sat_lane ? lim[QB-1:0] : quo_q[QB][r][c];
        inv_d[r][c] = sf.singular ? '0
                    : (sf.neg[r*3+c] ? signed'(-qs) : signed'(qs));
        sat_d    = sat_d || (sat_lane && !sf.singular);
      end
    end
    if (sf.singular) begin
      status_d = jdi_pkg::STATUS_SINGULAR;
    end else if (sf.detneg) begin
      status_d = jdi_pkg::STATUS_NEG_DET;
    end else begin
      status_d = jdi_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_o.inv_row0_col0 <= inv_d[0][0];
      out_o.inv_row1_col0 <= inv_d[1][0];
      out_o.inv_row2_col0 <= inv_d[2][0];
      out_o.inv_row0_col1 <= inv_d[0][1];
      out_o.inv_row1_col1 <= inv_d[1][1];
      out_o.inv_row2_col1 <= inv_d[2][1];
      out_o.inv_row0_col2 <= inv_d[0][2];
      out_o.inv_row1_col2 <= inv_d[1][2];
      out_o.inv_row2_col2 <= inv_d[2][2];
      out_o.det_magnitude <= sf.singular ? '0 : sf.detm;
      out_o.status        <= status_d;
      out_o.saturated     <= sat_d;
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench for jacobian_det_and_inverse: directed and random Jacobians with a
// bit-exact determinant/inverse predictor. Depends on jdi_pkg and jdi_if.sv.
module tb;

  typedef logic [8:0][15:0] jac_t;  // index = col*3 + row

  typedef struct packed {
    logic [8:0][jdi_pkg::INV_W-1:0] inv;     // index = col*3 + row
    logic [jdi_pkg::DETM_W-1:0]     det;
    jdi_pkg::status_e               status;
    logic                           sat;
  } inv_res_t;

  localparam int DRAIN_CYCLES = 45;
  localparam int CYCLE_LIMIT  = 2000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = 2'd3;

  jdi_in_if #(.EntryBits(16)) in_if ();
  jdi_out_if out_if ();

  jacobian_det_and_inverse #(.ENTRY_BITS(16)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  inv_res_t    inverse_q[$];
  logic [1:0]  order_cfg = 2'd3;
  int          fail_cnt = 0;
  int          hold_cycles = 0;   // long receiver hold-off, counted in receiver
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  longint      cycle_cnt = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Bit-exact model: cofactor expansion along column 0, adjugate over det.
  function automatic inv_res_t predict_inverse(jac_t m);
    longint      a[3][3];
    longint      adj[3][3];
    longint      det;
    longint      v;
    logic [127:0] mag, num, q, limit;
    bit          dneg, neg;
    int          n;
    inv_res_t    res;
    res = '0;
    n = (order_cfg == 2'd0) ? 1 : int'(order_cfg);
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) begin
        a[r][c] = longint'($signed(m[c*3+r]));
        adj[r][c] = 0;
      end
    if (n == 3) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          adj[i][j] = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
                    - a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
      det = a[0][0]*adj[0][0] + a[1][0]*adj[0][1] + a[2][0]*adj[0][2];
    end else if (n == 2) begin
      adj[0][0] = a[1][1];
      adj[0][1] = -a[0][1];
      adj[1][0] = -a[1][0];
      adj[1][1] = a[0][0];
      det = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    end else begin
      adj[0][0] = 1;
      det = a[0][0];
    end
    if (det == 0) begin
      res.status = jdi_pkg::STATUS_SINGULAR;
      return res;
    end
    dneg = det < 0;
    mag = 128'(dneg ? -det : det);
    // rescale |det| to Q12.36
    res.det = (n == 3) ? mag[47:0] : (n == 2) ? 48'(mag << 12) : 48'(mag << 24);
    res.status = dneg ? jdi_pkg::STATUS_NEG_DET : jdi_pkg::STATUS_OK;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        v = adj[i][j];
        num = 128'((v < 0) ? -v : v);
        num = num << (jdi_pkg::INV_FRAC + 12);
        q = num / mag;
        neg = (v < 0) != dneg;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > limit) begin
          q = limit;
          res.sat = 1'b1;
        end
        res.inv[j*3+i] = neg ? -q[31:0] : q[31:0];
      end
    return res;
  endfunction

  // Receiver: random stall pattern whose mode is redrawn each time its phase counter wraps,
  // overridden by a long hold-off when a test asks for one.
  initial begin
    static int mode = 0;
    static int phase = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        if (phase == 0) mode = $urandom_range(0, 3);
        phase = (phase + 1) % 256;
        case (mode)
          0: begin
            out_if.ready = 1'b1;
          end
          1: begin
            out_if.ready = ($urandom_range(0, 99) < 70);
          end
          2: begin
            out_if.ready = ($urandom_range(0, 99) < 25);
          end
          default: begin
            out_if.ready = phase[0];
          end
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    inv_res_t got, exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.inv = {out_if.inv_row2_col2, out_if.inv_row1_col2, out_if.inv_row0_col2,
                 out_if.inv_row2_col1, out_if.inv_row1_col1, out_if.inv_row0_col1,
                 out_if.inv_row2_col0, out_if.inv_row1_col0, out_if.inv_row0_col0};
      got.det = out_if.det_magnitude;
      got.status = jdi_pkg::status_e'(out_if.status);
      got.sat = out_if.saturated;
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result beat, det %h status %0d", $time, got.det,
                 got.status);
        fail_cnt++;
      end else begin
        exp_r = inverse_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got.inv[k] !== exp_r.inv[k]) begin
            $display("%0t: inv row%0d col%0d expected %h actual %h", $time, k % 3,
                     k / 3, exp_r.inv[k], got.inv[k]);
            fail_cnt++;
          end
        if (got.det !== exp_r.det) begin
          $display("%0t: det_magnitude expected %h actual %h", $time, exp_r.det,
                   got.det);
          fail_cnt++;
        end
        if (got.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   got.status);
          fail_cnt++;
        end
        if (got.sat !== exp_r.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, got.sat);
          fail_cnt++;
        end
      end
    end
  end

  // Sends one Jacobian beat; may idle between bursts unless told not to.
  task automatic send_jacobian(jac_t m);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!no_gaps && $urandom_range(0, 2) != 0) begin
        in_if.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid = 1'b1;
    {in_if.row2_col2, in_if.row1_col2, in_if.row0_col2,
     in_if.row2_col1, in_if.row1_col1, in_if.row0_col1,
     in_if.row2_col0, in_if.row1_col0, in_if.row0_col0} = m;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    inverse_q.push_back(predict_inverse(m));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid = 1'b0;
    wait (inverse_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Order register write, only with the pipeline empty
  task automatic write_order(logic [1:0] ord);
    drain_results();
    cfg_we_i = 1'b1;
    cfg_wdata_i = ord;
    @(posedge clk_i);
    order_cfg = ord;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic jac_t rows(int r0c0, int r0c1, int r0c2, int r1c0, int r1c1,
                                int r1c2, int r2c0, int r2c1, int r2c2);
    jac_t m;
    m[0] = 16'(r0c0); m[1] = 16'(r1c0); m[2] = 16'(r2c0);
    m[3] = 16'(r0c1); m[4] = 16'(r1c1); m[5] = 16'(r2c1);
    m[6] = 16'(r0c2); m[7] = 16'(r1c2); m[8] = 16'(r2c2);
    return m;
  endfunction

  function automatic jac_t random_jacobian();
    jac_t m;
    int   k;
    k = $urandom_range(0, 5);
    for (int i = 0; i < 9; i++) begin
      case (k)
        0: m[i] = 16'($urandom);
        1: m[i] = 16'(((i % 4) == 0 ? 4096 : 0) + $signed($urandom_range(0, 4095)) - 2048);
        3: m[i] = ($urandom_range(0, 2) == 0) ? 16'h8000 :
                  ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h0000;
        4: m[i] = 16'($signed($urandom_range(0, 15)) - 8);
        default: m[i] = 16'($signed($urandom_range(0, 16383)) - 8192);
      endcase
    end
    // near-singular pattern: last row near the sum of the first two, then row 1 nudged toward row 0
    if (k == 2) begin
      m[2] = 16'(m[0] + m[1] + $urandom_range(0, 2));
      m[5] = m[3] + m[4];
      m[8] = 16'(m[6] + m[7] + $urandom_range(0, 1));
      m[1] = 16'(m[0] + $urandom_range(0, 1));
      m[4] = 16'(m[3] - $urandom_range(0, 1));
    end
    return m;
  endfunction

  task automatic test_directed();
    for (int ord = 0; ord < 4; ord++) begin
      write_order(ord[1:0]);
      send_jacobian(rows(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));     // identity
      send_jacobian('0);                                            // singular
      send_jacobian({9{16'h8000}});                                 // most negative
      send_jacobian({9{16'h7FFF}});
      send_jacobian(rows(0, 4096, 0, 4096, 0, 0, 0, 0, 4096));     // negative det
      send_jacobian(rows(100, 99, 7, 101, 100, 3, 5, 9, 1));       // saturating 2x2
      send_jacobian(rows(99, 100, 0, 100, 101, 0, 0, 0, 1));       // negative, tiny det
      send_jacobian(rows(0, 1234, -5, 777, -3, 88, 99, 31000, -32768)); // singular as 1x1
      send_jacobian(rows(-32768, 32767, 1, 32767, -32768, -1, 1, -1, 32767));
    end
  endtask

  task automatic test_random_orders();
    int plan[4] = '{3, 1, 2, 0};
    foreach (plan[p]) begin
      write_order(plan[p][1:0]);
      repeat (420) send_jacobian(random_jacobian());
    end
  endtask

  // Receiver holds off while the sender keeps offering beats back to back.
  task automatic test_backpressure();
    write_order(2'd3);
    no_gaps = 1'b1;
    hold_cycles = 300;
    repeat (150) send_jacobian(random_jacobian());
    no_gaps = 1'b0;
  endtask

  // Sender pauses until every result is out, then resumes.
  task automatic test_drain_pause();
    repeat (30) send_jacobian(random_jacobian());
    drain_results();
    repeat (30) send_jacobian(random_jacobian());
  endtask

  initial begin
    in_if.valid = 1'b0;
    {in_if.row2_col2, in_if.row1_col2, in_if.row0_col2,
     in_if.row2_col1, in_if.row1_col1, in_if.row0_col1,
     in_if.row2_col0, in_if.row1_col0, in_if.row0_col0} = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_orders();
    test_backpressure();
    test_drain_pause();
    drain_results();
    if (fail_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/jdi_pkg.sv
rtl/jdi_if.sv
rtl/jacobian_det_and_inverse.sv
tb/sv/tb.sv
